// ===== hdl/dps_pkg.sv =====
package dps_pkg;

	localparam int PATTERN_BITS = 8;
	localparam int STORED_BITS  = 8;
	localparam int POS_W        = (PATTERN_BITS > 1) ? $clog2(PATTERN_BITS) : 1;
	localparam int RUN_W        = $clog2(PATTERN_BITS + 1);
	localparam int LEN_W        = 10;
	localparam int SUB_SHIFT    = 4;
	localparam int SCALE_W      = 8;
	localparam int REM_W        = 15;
	localparam int PROD_W       = RUN_W + SCALE_W + SUB_SHIFT;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;

	localparam logic [LEN_W-1:0]      MAX_SEG       = LEN_W'(992);
	localparam logic [REM_W-1:0]      REM_MAX       = REM_W'(32767);
	localparam logic [CFG_IDX_W-1:0]  REG_PATTERN   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0]  REG_SCALE     = CFG_IDX_W'(1);
	localparam logic [STORED_BITS-1:0] PATTERN_RST  = STORED_BITS'(128);
	localparam logic [SCALE_W-1:0]    SCALE_RST     = SCALE_W'(1);

	typedef struct packed {
		logic load;
		logic fetch;
		logic cut;
	} dps_cmd_t;

	typedef struct packed {
		logic rem_zero;
		logic fits;
		logic draw;
		logic out_free;
	} dps_sts_t;

endpackage

// ===== hdl/dps_ctrl.sv =====
module dps_ctrl
	import dps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dps_sts_t sts,
	output dps_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_CUT   = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.fetch = (state_q == S_FETCH);
	assign cmd.cut   = (state_q == S_CUT) && (!sts.draw || sts.out_free);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.load) begin
					state_d = sts.rem_zero ? S_FETCH : S_CUT;
				end
			end
			S_FETCH: begin
				state_d = S_CUT;
			end
			S_CUT: begin
				if (cmd.cut) begin
					state_d = sts.fits ? S_IDLE : S_FETCH;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/dps_datapath.sv =====
module dps_datapath
	import dps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [LEN_W-1:0]      segment_length,
	input  logic                  is_draw,
	input  dps_cmd_t              cmd,
	output dps_sts_t              sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  piece_pen,
	output logic [LEN_W-1:0]      piece_length,
	output logic                  last_piece
);

	logic [STORED_BITS-1:0] pattern_q;
	logic [SCALE_W-1:0]     scale_q;
	logic [POS_W-1:0]       pos_q;
	logic [REM_W-1:0]       rem_q;
	logic                   pen_q;
	logic [LEN_W-1:0]       togo_q;
	logic                   draw_q;
	logic                   out_valid_q;
	logic                   out_pen_q;
	logic [LEN_W-1:0]       out_len_q;
	logic                   out_last_q;

	logic [PATTERN_BITS-1:0] pens;
	logic [RUN_W-1:0]        run;
	logic [POS_W:0]          pos_sum;
	logic [POS_W-1:0]        pos_next;
	logic [SCALE_W-1:0]      scale_eff;
	logic [PROD_W-1:0]       dash_len;
	logic [REM_W-1:0]        dash_rem;
	logic [LEN_W-1:0]        seg_clamped;
	logic                    emit;

	always_comb begin
		logic [POS_W:0] idx;
		for (int i = 0; i < PATTERN_BITS; i++) begin
			idx = {1'b0, pos_q} + (POS_W+1)'(i);
			if (idx >= (POS_W+1)'(PATTERN_BITS)) begin
				idx = idx - (POS_W+1)'(PATTERN_BITS);
			end
			if (idx < (POS_W+1)'(STORED_BITS)) begin
				pens[i] = ~pattern_q[idx[$clog2(STORED_BITS)-1:0]];
			end else begin
				pens[i] = 1'b1;
			end
		end
	end

	always_comb begin
		run = RUN_W'(PATTERN_BITS);
		for (int i = PATTERN_BITS - 1; i > 0; i--) begin
			if (pens[i] != pens[0]) begin
				run = RUN_W'(i);
			end
		end
	end

	always_comb begin
		pos_sum = {1'b0, pos_q} + (POS_W+1)'(run);
		if (pos_sum >= (POS_W+1)'(PATTERN_BITS)) begin
			pos_sum = pos_sum - (POS_W+1)'(PATTERN_BITS);
		end
		pos_next = pos_sum[POS_W-1:0];
	end

	assign scale_eff = (scale_q == '0) ? SCALE_W'(1) : scale_q;
	assign dash_len  = (PROD_W'(run) * PROD_W'(scale_eff)) << SUB_SHIFT;
	assign dash_rem  = (dash_len > PROD_W'(REM_MAX)) ? REM_MAX : dash_len[REM_W-1:0];

	assign seg_clamped = (segment_length > MAX_SEG) ? MAX_SEG : segment_length;

	assign sts.rem_zero = (rem_q == '0);
	assign sts.fits     = (REM_W'(togo_q) <= rem_q);
	assign sts.draw     = draw_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign emit = cmd.cut && draw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PATTERN_RST;
			scale_q   <= SCALE_RST;
			pos_q     <= '0;
			rem_q     <= '0;
			pen_q     <= 1'b0;
		end else if (cfg_we && (cfg_index == REG_PATTERN || cfg_index == REG_SCALE)) begin
			if (cfg_index == REG_PATTERN) begin
				pattern_q <= cfg_data[STORED_BITS-1:0];
			end else begin
				scale_q <= cfg_data[SCALE_W-1:0];
			end
			pos_q <= '0;
			rem_q <= '0;
		end else if (cmd.fetch) begin
			pos_q <= pos_next;
			rem_q <= dash_rem;
			pen_q <= pens[0];
		end else if (cmd.cut) begin
			if (sts.fits) begin
				rem_q <= rem_q - REM_W'(togo_q);
			end else begin
				rem_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			togo_q <= seg_clamped;
			draw_q <= is_draw;
		end else if (cmd.cut && !sts.fits) begin
			togo_q <= togo_q - rem_q[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pen_q  <= pen_q;
			out_len_q  <= sts.fits ? togo_q : rem_q[LEN_W-1:0];
			out_last_q <= sts.fits;
		end
	end

	assign out_valid    = out_valid_q;
	assign piece_pen    = out_pen_q;
	assign piece_length = out_len_q;
	assign last_piece   = out_last_q;

endmodule

// ===== hdl/dash_pattern_segmenter.sv =====
// Cuts each line segment into dash pieces along a circular 8-bit pattern (bit 0 first, a zero
// bit draws). Takes one segment at a time: it accepts the segment, then fetches a new dash
// whenever the current one is used up and cuts one piece per step, the fetch and cut steps
// sharing one datapath; output back-pressure stalls the cut of a drawn piece.
// A zero-length drawn segment yields one piece of length 0. Moves yield no pieces but advance
// the pattern. Writing either register restarts the pattern; write only while idle.
module dash_pattern_segmenter
	import dps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [LEN_W-1:0]      segment_length,
	input  logic                  is_draw,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  piece_pen,
	output logic [LEN_W-1:0]      piece_length,
	output logic                  last_piece
);

	dps_cmd_t cmd;
	dps_sts_t sts;

	dps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dps_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.segment_length (segment_length),
		.is_draw        (is_draw),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.piece_pen      (piece_pen),
		.piece_length   (piece_length),
		.last_piece     (last_piece)
	);

`ifndef SYNTHESIS
	a_fetch_loads_dash: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch && !cfg_we |=> !sts.rem_zero)
		else $error("fetch left no dash length");

	a_last_cut_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cut && sts.fits |=> in_ready)
		else $error("final cut did not return to idle");

	a_piece_from_cut: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.cut && sts.draw))
		else $error("piece issued without a drawn cut");
`endif

endmodule
